/* rtl/source_token_scanner_unit_defines.svh */
// Assertion macros used by the scanner RTL (sts_scan).
// Define NO_ASSERTIONS to compile the checks out.
`ifndef SOURCE_TOKEN_SCANNER_UNIT_DEFINES_SVH
`define SOURCE_TOKEN_SCANNER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define STSU_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("scanner check failed");

// Condition in one cycle implies a condition in the next cycle.
`define STSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scanner sequence check failed");

`else

`define STSU_ASSERT(lbl, clk, rst_n, prop)
`define STSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/sts_pkg.sv */
package sts_pkg;

	// Character codes
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_V     = 8'h76;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_R     = 8'h72;

	localparam int LEN_W = 7;
	localparam int POS_W = 16;
	localparam logic [POS_W-1:0] POS_MAX = '1;
	localparam logic [LEN_W-1:0] KW_LEN = 7'd3;

	// Result queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_PLUS,
		MODE_MINUS,
		MODE_SLASH,
		MODE_COMMENT,
		MODE_WORD
	} mode_t;

	typedef enum logic [3:0] {
		KIND_PLUS,
		KIND_PLUS_EQ,
		KIND_MINUS,
		KIND_MINUS_EQ,
		KIND_STAR,
		KIND_SLASH,
		KIND_EQ,
		KIND_MOD,
		KIND_LT,
		KIND_GT,
		KIND_COMMENT,
		KIND_NUMBER,
		KIND_IDENT,
		KIND_VAR,
		KIND_ERROR
	} kind_t;

	typedef enum logic [2:0] {
		NUM_START,
		NUM_INT,
		NUM_INT_US,
		NUM_DOT,
		NUM_FRAC,
		NUM_FRAC_US,
		NUM_DEAD
	} num_t;

	// Incremental word classifier state
	typedef struct packed {
		logic [LEN_W-1:0] len;
		num_t             num;
		logic             name_ok;
		logic [1:0]       kw;
	} word_t;

	localparam word_t WORD_INIT = '{len: '0, num: NUM_START, name_ok: 1'b1, kw: 2'd0};

	typedef struct packed {
		kind_t            kind;
		logic [POS_W-1:0] line;
		logic [POS_W-1:0] column;
	} token_t;

	// Up to two tokens per item; first is emitted before second
	typedef struct packed {
		logic [1:0] valid;
		token_t     first;
		token_t     second;
	} emit_t;

	typedef struct packed {
		token_t tok;
		logic   last;
	} entry_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	function automatic logic is_word_end(input logic [7:0] c);
		return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic [7:0] kw_char(input logic [1:0] idx);
		logic [7:0] ch;
		case (idx)
			2'd0:    ch = CH_V;
			2'd1:    ch = CH_A;
			2'd2:    ch = CH_R;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// Feed one character into the word classifier
	function automatic word_t word_add(input word_t w, input logic [7:0] c,
	                                   input logic [LEN_W-1:0] max_len);
		word_t r;
		r = w;
		if (w.len >= max_len) begin
			r.num = NUM_DEAD;
			r.name_ok = 1'b0;
		end else begin
			// number pattern
			if (is_digit(c)) begin
				case (w.num)
					NUM_START, NUM_INT, NUM_INT_US: r.num = NUM_INT;
					NUM_DOT, NUM_FRAC, NUM_FRAC_US: r.num = NUM_FRAC;
					default:                        r.num = NUM_DEAD;
				endcase
			end else if (c == CH_USCORE) begin
				case (w.num)
					NUM_INT:  r.num = NUM_INT_US;
					NUM_FRAC: r.num = NUM_FRAC_US;
					default:  r.num = NUM_DEAD;
				endcase
			end else if (c == CH_DOT) begin
				r.num = (w.num == NUM_INT) ? NUM_DOT : NUM_DEAD;
			end else begin
				r.num = NUM_DEAD;
			end
			// identifier pattern
			if (w.len == '0) begin
				if (!is_letter(c))
					r.name_ok = 1'b0;
			end else if (!(is_letter(c) || is_digit(c) || (c == CH_USCORE))) begin
				r.name_ok = 1'b0;
			end
			// keyword prefix match
			if ((w.kw != 2'd3) && ({5'd0, w.kw} == w.len) && (c == kw_char(w.kw)))
				r.kw = w.kw + 2'd1;
			r.len = w.len + 1'b1;
		end
		return r;
	endfunction

	function automatic kind_t word_kind(input word_t w);
		kind_t k;
		if ((w.num == NUM_INT) || (w.num == NUM_FRAC))
			k = KIND_NUMBER;
		else if (w.name_ok)
			k = ((w.kw == 2'd3) && (w.len == KW_LEN)) ? KIND_VAR : KIND_IDENT;
		else
			k = KIND_ERROR;
		return k;
	endfunction

endpackage

/* rtl/sts_scan.sv */
`include "source_token_scanner_unit_defines.svh"

module sts_scan #(
	parameter int MAX_WORD_CHARS = 63
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     text_byte,
	input  logic           end_of_text,
	output sts_pkg::emit_t emit
);
	import sts_pkg::*;

	localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_WORD_CHARS);

	mode_t            mode_q, mode_n, i_mode;
	word_t            word_q, word_n, i_word;
	logic [POS_W-1:0] line_q, line_n, col_q, col_n;
	logic [POS_W-1:0] start_line_q, start_col_q;
	logic             start_set;
	logic             i_emit, i_start, use_idle, p_emit;
	kind_t            i_kind, p_kind;
	token_t           p_tok, i_tok;

	// What the byte would do if seen in idle
	always_comb begin
		i_mode  = MODE_IDLE;
		i_emit  = 1'b0;
		i_kind  = KIND_ERROR;
		i_start = 1'b0;
		i_word  = word_add(WORD_INIT, text_byte, MaxLen);
		case (text_byte)
			CH_SP, CH_CR, CH_TAB, CH_LF: begin
				i_mode = MODE_IDLE;
			end
			CH_PLUS:  begin i_mode = MODE_PLUS;  i_start = 1'b1; end
			CH_MINUS: begin i_mode = MODE_MINUS; i_start = 1'b1; end
			CH_SLASH: begin i_mode = MODE_SLASH; i_start = 1'b1; end
			CH_STAR:  begin i_emit = 1'b1; i_kind = KIND_STAR; end
			CH_EQ:    begin i_emit = 1'b1; i_kind = KIND_EQ; end
			CH_PCT:   begin i_emit = 1'b1; i_kind = KIND_MOD; end
			CH_LT:    begin i_emit = 1'b1; i_kind = KIND_LT; end
			CH_GT:    begin i_emit = 1'b1; i_kind = KIND_GT; end
			default: begin
				i_mode  = MODE_WORD;
				i_start = 1'b1;
			end
		endcase
	end

	// Mode transitions and pending token flush
	always_comb begin
		mode_n   = mode_q;
		word_n   = word_q;
		p_emit   = 1'b0;
		p_kind   = KIND_ERROR;
		use_idle = 1'b0;
		if (end_of_text) begin
			case (mode_q)
				MODE_PLUS:  begin p_emit = 1'b1; p_kind = KIND_PLUS; end
				MODE_MINUS: begin p_emit = 1'b1; p_kind = KIND_MINUS; end
				MODE_SLASH: begin p_emit = 1'b1; p_kind = KIND_SLASH; end
				MODE_WORD:  begin p_emit = 1'b1; p_kind = word_kind(word_q); end
				default:    p_emit = 1'b0;
			endcase
			mode_n = MODE_IDLE;
		end else begin
			case (mode_q)
				MODE_PLUS: begin
					p_emit = 1'b1;
					if (text_byte == CH_EQ) begin
						p_kind = KIND_PLUS_EQ;
						mode_n = MODE_IDLE;
					end else begin
						p_kind   = KIND_PLUS;
						use_idle = 1'b1;
					end
				end
				MODE_MINUS: begin
					p_emit = 1'b1;
					if (text_byte == CH_EQ) begin
						p_kind = KIND_MINUS_EQ;
						mode_n = MODE_IDLE;
					end else begin
						p_kind   = KIND_MINUS;
						use_idle = 1'b1;
					end
				end
				MODE_SLASH: begin
					p_emit = 1'b1;
					if (text_byte == CH_SLASH) begin
						p_kind = KIND_COMMENT;
						mode_n = MODE_COMMENT;
					end else begin
						p_kind   = KIND_SLASH;
						use_idle = 1'b1;
					end
				end
				MODE_COMMENT: begin
					if (text_byte == CH_LF)
						mode_n = MODE_IDLE;
				end
				MODE_WORD: begin
					if (is_word_end(text_byte)) begin
						p_emit = 1'b1;
						p_kind = word_kind(word_q);
						mode_n = MODE_IDLE;
					end else begin
						word_n = word_add(word_q, text_byte, MaxLen);
					end
				end
				default: use_idle = 1'b1;
			endcase
		end
		if (use_idle) begin
			mode_n = i_mode;
			if (i_mode == MODE_WORD)
				word_n = i_word;
		end
	end

	assign start_set = use_idle && i_start;

	// Position tracking, saturating
	always_comb begin
		line_n = line_q;
		col_n  = col_q;
		if (!end_of_text) begin
			if (text_byte == CH_LF) begin
				if (line_q != POS_MAX)
					line_n = line_q + 1'b1;
				col_n = POS_W'(1);
			end else if (col_q != POS_MAX) begin
				col_n = col_q + 1'b1;
			end
		end
	end

	// Pack results in emission order
	always_comb begin
		p_tok.kind   = p_kind;
		p_tok.line   = start_line_q;
		p_tok.column = start_col_q;
		i_tok.kind   = i_kind;
		i_tok.line   = line_q;
		i_tok.column = col_q;
		emit.valid[0] = step && (p_emit || (use_idle && i_emit));
		emit.valid[1] = step && p_emit && use_idle && i_emit;
		emit.first    = p_emit ? p_tok : i_tok;
		emit.second   = i_tok;
	end

	// Scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			word_q       <= WORD_INIT;
			line_q       <= POS_W'(1);
			col_q        <= POS_W'(1);
			start_line_q <= '0;
			start_col_q  <= '0;
		end else if (step) begin
			mode_q <= mode_n;
			word_q <= word_n;
			line_q <= line_n;
			col_q  <= col_n;
			if (start_set) begin
				start_line_q <= line_q;
				start_col_q  <= col_q;
			end
		end
	end

	`STSU_ASSERT(a_len_bound, clk, arst_n, word_q.len <= MaxLen)
	`STSU_ASSERT(a_second_needs_first, clk, arst_n, !emit.valid[1] || emit.valid[0])
	`STSU_ASSERT_NEXT(a_comment_entry, clk, arst_n, mode_q != MODE_SLASH && mode_q != MODE_COMMENT, mode_q != MODE_COMMENT)

endmodule

/* rtl/sts_result_fifo.sv */
module sts_result_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  sts_pkg::emit_t emit,
	output logic           room,
	output logic           out_valid,
	input  logic           out_ready,
	output sts_pkg::entry_t out_entry
);
	import sts_pkg::*;

	entry_t             mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_CW-1:0] count_q;
	logic               pop;
	logic [FIFO_CW-1:0] n_push;

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign out_entry = mem_q[rd_q];
	// two free slots needed: an item may produce two tokens
	assign room      = (count_q <= FIFO_CW'(FIFO_DEPTH - 2));
	assign n_push    = FIFO_CW'(emit.valid[0]) + FIFO_CW'(emit.valid[1]);

	// Entry storage
	always_ff @(posedge clk) begin
		if (emit.valid[0]) begin
			mem_q[wr_q].tok  <= emit.first;
			mem_q[wr_q].last <= !emit.valid[1];
		end
		if (emit.valid[1]) begin
			mem_q[wr_q + 1'b1].tok  <= emit.second;
			mem_q[wr_q + 1'b1].last <= 1'b1;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + FIFO_AW'(n_push);
			if (pop)
				rd_q <= rd_q + 1'b1;
			count_q <= count_q + n_push - FIFO_CW'(pop);
		end
	end

endmodule

/* rtl/source_token_scanner_unit.sv */
// Source text tokenizer. One text byte (or an end marker on tlast) is taken per
// cycle; each item yields zero, one or two tokens with kind, line and column of
// the token's first character, the final token of an item flagged on tlast.
// A byte is registered on acceptance, scanned once the result queue has room, and
// its tokens are written to that queue for output. The input keeps a rate
// of one item per cycle while tokens drain at least as fast as they appear; the
// output moves one token per cycle, so an item that gives two tokens costs a
// second output cycle, absorbed by a four-entry result queue that must hold two
// free slots before the next byte is scanned.
module source_token_scanner_unit #(
	parameter int MAX_WORD_CHARS = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
	input  logic        s_axis_tlast,   // end_of_text
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [3:0] token_kind, [19:4] token_line,
	                                    // [35:20] token_column, [39:36] zero
	output logic        m_axis_tlast    // last_of_run
);
	import sts_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;
	logic       room;
	logic       step;
	emit_t      emit;
	entry_t     out_entry;

	assign step          = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || step;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			eot_s1  <= s_axis_tlast;
		end
	end

	sts_scan #(
		.MAX_WORD_CHARS(MAX_WORD_CHARS)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.text_byte   (byte_s1),
		.end_of_text (eot_s1),
		.emit        (emit)
	);

	sts_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_entry (out_entry)
	);

	// Output packing
	assign m_axis_tdata = {4'b0000, out_entry.tok.column, out_entry.tok.line,
	                       out_entry.tok.kind};
	assign m_axis_tlast = out_entry.last;

endmodule
